// ===== sv/barometric_pressure_compensation_top_assert.svh =====
// Assertion macros for the pressure compensation block
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_TOP_ASSERT_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define BPC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define BPC_ASSERT_RST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define BPC_ASSERT(label, clk, rst, prop)
`define BPC_ASSERT_RST(label, clk, prop)
`endif
`endif

// ===== sv/bpc_pkg.sv =====
package bpc_pkg;
   localparam int RawWidth = 20;
   localparam int WordWidth = 32;
   localparam int CsrDataWidth = 64;
   localparam int CsrIndexWidth = 2;
   localparam int QuotWidth = 33;

   localparam logic [CsrIndexWidth-1:0] CSR_TEMP_TRIM = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_PRES_TRIM_A = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_PRES_TRIM_B = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_PRES_TRIM_C = 2'd3;

   localparam logic [31:0] OFFSET_64000 = 32'd64000;
   localparam logic [31:0] OFFSET_1M = 32'd1048576;
   localparam logic [31:0] SCALE_3125 = 32'd3125;
   localparam logic [31:0] HALF_SCALE = 32'd32768;

   typedef logic [31:0] word_type;

   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
   } trim_type;

   function automatic word_type sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic word_type sra(input word_type x, input int s);
      return word_type'($signed(x) >>> s);
   endfunction
endpackage

// ===== sv/bpc_req_if.sv =====
interface bpc_req_if;
   logic valid;
   logic ready;
   logic [19:0] raw_pressure;
   logic [19:0] raw_temperature;
   modport source(output valid, raw_pressure, raw_temperature, input ready);
   modport sink(input valid, raw_pressure, raw_temperature, output ready);
endinterface

// ===== sv/bpc_rsp_if.sv =====
interface bpc_rsp_if;
   logic valid;
   logic ready;
   logic [31:0] pressure_pa;
   logic [31:0] fine_temperature;
   logic zero_divisor;
   modport source(output valid, pressure_pa, fine_temperature, zero_divisor, input ready);
   modport sink(input valid, pressure_pa, fine_temperature, zero_divisor, output ready);
endinterface

// ===== sv/bpc_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, MSB first.
module bpc_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [bpc_pkg::QuotWidth-1:0] dividend,
   input  logic [31:0]                 divisor,
   input  logic [63:0]                 side_in,
   output logic                        out_valid,
   output logic [bpc_pkg::QuotWidth-1:0] quotient,
   output logic [63:0]                 side_out
);
   import bpc_pkg::*;
   localparam int N = QuotWidth;

   logic [N:1]       vld_ff;
   logic [N-1:0]     num_ff [1:N];
   logic [32:0]      rem_ff [1:N-1];
   logic [31:0]      dvs_ff [1:N-1];
   logic [63:0]      side_ff [1:N];

   logic [N-1:0]     num_in [1:N];
   logic [32:0]      rem_in [1:N-1];
   logic [31:0]      dvs_in [1:N-1];

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic [N-1:0] num_cur;
      logic [32:0]  rem_cur;
      logic [31:0]  dvs_cur;
      logic [33:0]  trial;
      logic         qbit;
      // first stage reads the ports directly
      if (i == 0) begin : g_first
         assign num_cur = dividend;
         assign rem_cur = '0;
         assign dvs_cur = divisor;
      end else begin : g_next
         assign num_cur = num_ff[i];
         assign rem_cur = rem_ff[i];
         assign dvs_cur = dvs_ff[i];
      end
      assign trial = {rem_cur, num_cur[N-1]};
      assign qbit = trial >= {2'b00, dvs_cur};
      assign num_in[i+1] = {num_cur[N-2:0], qbit};
      if (i < N - 1) begin : g_pass
         assign rem_in[i+1] = qbit ? 33'(trial - {2'b00, dvs_cur}) : trial[32:0];
         assign dvs_in[i+1] = dvs_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[N-1:1], in_valid};
      end
      if (advance) begin
         for (int i = 1; i <= N; i++) begin
            num_ff[i] <= num_in[i];
         end
         for (int i = 1; i < N; i++) begin
            rem_ff[i] <= rem_in[i];
            dvs_ff[i] <= dvs_in[i];
         end
         side_ff[1] <= side_in;
         for (int i = 2; i <= N; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign quotient = num_ff[N];
   assign side_out = side_ff[N];
endmodule

// ===== sv/barometric_pressure_compensation_top.sv =====
// Pressure compensation pipeline: takes one raw pressure/temperature pair per
// clock unless stalled and returns pressure in pascals plus the fine
// temperature. It has 9 arithmetic stages, 33 divider stages, 3 final trim
// stages and 1 output stage; throughput is one item per cycle when not
// stalled, set by the fully pipelined bit-per-stage divider. A stall on the
// result side freezes the whole pipeline.
`include "barometric_pressure_compensation_top_assert.svh"
module barometric_pressure_compensation_top (
   input  logic        clock,
   input  logic        reset,
   bpc_req_if.sink     req,
   bpc_rsp_if.source   rsp,
   input  logic        csr_write,
   input  logic [bpc_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [bpc_pkg::CsrDataWidth-1:0]  csr_data
);
   import bpc_pkg::*;

   trim_type trim_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         trim_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TEMP_TRIM: {trim_ff.t3, trim_ff.t2, trim_ff.t1} <= csr_data[47:0];
            CSR_PRES_TRIM_A: {trim_ff.p4, trim_ff.p3, trim_ff.p2, trim_ff.p1} <= csr_data;
            CSR_PRES_TRIM_B: {trim_ff.p8, trim_ff.p7, trim_ff.p6, trim_ff.p5} <= csr_data;
            CSR_PRES_TRIM_C: trim_ff.p9 <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   word_type t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   assign t1 = {16'd0, trim_ff.t1};
   assign t2 = sx16(trim_ff.t2);
   assign t3 = sx16(trim_ff.t3);
   assign p1 = {16'd0, trim_ff.p1};
   assign p2 = sx16(trim_ff.p2);
   assign p3 = sx16(trim_ff.p3);
   assign p4 = sx16(trim_ff.p4);
   assign p5 = sx16(trim_ff.p5);
   assign p6 = sx16(trim_ff.p6);
   assign p7 = sx16(trim_ff.p7);
   assign p8 = sx16(trim_ff.p8);
   assign p9 = sx16(trim_ff.p9);

   // output register: pipeline advances when the output register is empty or being taken
   logic out_valid_ff;
   logic advance;
   assign advance = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   // ---- front stages ----
   logic [9:1] v_ff;
   word_type s1_x_ff, s1_d_ff, s1_praw_ff;
   word_type s2_a_ff, s2_dd_ff, s2_praw_ff;
   word_type s3_a_ff, s3_m_ff, s3_praw_ff;
   word_type s4_fine_ff, s4_praw_ff;
   word_type s5_fine_ff, s5_a_ff, s5_sq_ff, s5_praw_ff;
   word_type s6_fine_ff, s6_b1_ff, s6_a5_ff, s6_x3_ff, s6_x2_ff, s6_praw_ff;
   word_type s7_fine_ff, s7_b_ff, s7_x_ff, s7_praw_ff;
   word_type s8_fine_ff, s8_d_ff, s8_b_ff;
   word_type s9_fine_ff, s9_d_ff, s9_p_ff;

   word_type fine_w, a_w, sq_w, b_w;
   assign fine_w = s3_a_ff + sra(word_type'(s3_m_ff * t3), 14);
   assign a_w = sra(s4_fine_ff, 1) - OFFSET_64000;
   assign b_w = sra(sra(s6_b1_ff + s6_a5_ff, 0), 2) + (p4 << 16);
   assign sq_w = sra(s5_a_ff, 0);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[8:1], req.valid};
      end
      if (advance) begin
         s1_x_ff <= {15'd0, req.raw_temperature[19:3]} - (t1 << 1);
         s1_d_ff <= {16'd0, req.raw_temperature[19:4]} - t1;
         s1_praw_ff <= {12'd0, req.raw_pressure};
         s2_a_ff <= sra(word_type'(s1_x_ff * t2), 11);
         s2_dd_ff <= word_type'(s1_d_ff * s1_d_ff);
         s2_praw_ff <= s1_praw_ff;
         s3_a_ff <= s2_a_ff;
         s3_m_ff <= sra(s2_dd_ff, 12);
         s3_praw_ff <= s2_praw_ff;
         s4_fine_ff <= fine_w;
         s4_praw_ff <= s3_praw_ff;
         s5_fine_ff <= s4_fine_ff;
         s5_a_ff <= a_w;
         s5_sq_ff <= word_type'(sra(a_w, 2) * sra(a_w, 2));
         s5_praw_ff <= s4_praw_ff;
         s6_fine_ff <= s5_fine_ff;
         s6_b1_ff <= word_type'(sra(s5_sq_ff, 11) * p6);
         s6_a5_ff <= word_type'(sq_w * p5) << 1;
         s6_x3_ff <= sra(word_type'(p3 * sra(s5_sq_ff, 13)), 3);
         s6_x2_ff <= sra(word_type'(p2 * s5_a_ff), 1);
         s6_praw_ff <= s5_praw_ff;
         s7_fine_ff <= s6_fine_ff;
         s7_b_ff <= b_w;
         s7_x_ff <= HALF_SCALE + sra(s6_x3_ff + s6_x2_ff, 18);
         s7_praw_ff <= s6_praw_ff;
         s8_fine_ff <= s7_fine_ff;
         s8_d_ff <= sra(word_type'(s7_x_ff * p1), 15);
         s8_b_ff <= (OFFSET_1M - s7_praw_ff) - sra(s7_b_ff, 12);
         s9_fine_ff <= s8_fine_ff;
         s9_d_ff <= s8_d_ff;
         s9_p_ff <= word_type'(s8_b_ff * SCALE_3125);
      end
   end

   // p < 2^31: (p<<1)/d ; else (p/d)*2. Both as 33-bit dividend with a late fixup.
   logic [QuotWidth-1:0] div_num;
   logic                 big;
   assign big = s9_p_ff[31];
   assign div_num = big ? {1'b0, s9_p_ff} : {s9_p_ff, 1'b0};

   logic                 dv_valid;
   logic [QuotWidth-1:0] dv_q;
   logic [63:0]          dv_side;
   bpc_divider u_div (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(v_ff[9]), .dividend(div_num),
      .divisor(s9_d_ff == '0 ? 32'd1 : s9_d_ff),
      .side_in({s9_fine_ff, 30'd0, big, s9_d_ff == '0}),
      .out_valid(dv_valid), .quotient(dv_q), .side_out(dv_side)
   );

   // ---- back stages: final trim ----
   logic [3:1] w_ff;
   word_type t1_p_ff, t1_fine_ff; logic t1_z_ff;
   word_type t2_p_ff, t2_fine_ff, t2_a_ff, t2_b_ff; logic t2_z_ff;
   word_type t3_p_ff, t3_fine_ff, t3_sq_ff; logic t3_z_ff;
   word_type pq_w, q3;
   assign pq_w = dv_side[1] ? word_type'({dv_q[30:0], 1'b0}) : dv_q[31:0];
   assign q3 = t1_p_ff >> 3;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= '0;
      end else if (advance) begin
         w_ff <= {w_ff[2:1], dv_valid};
      end
      if (advance) begin
         t1_p_ff <= pq_w;
         t1_fine_ff <= dv_side[63:32];
         t1_z_ff <= dv_side[0];
         t3_sq_ff <= word_type'(q3 * q3) >> 13;
         t3_p_ff <= t1_p_ff;
         t3_fine_ff <= t1_fine_ff;
         t3_z_ff <= t1_z_ff;
         t2_a_ff <= sra(word_type'(p9 * t3_sq_ff), 12);
         t2_b_ff <= sra(word_type'((t3_p_ff >> 2) * p8), 13);
         t2_p_ff <= t3_p_ff;
         t2_fine_ff <= t3_fine_ff;
         t2_z_ff <= t3_z_ff;
      end
   end

   logic [31:0] rsp_p_ff, rsp_f_ff;
   logic        rsp_z_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= w_ff[3];
      end
      if (advance) begin
         rsp_p_ff <= t2_z_ff ? '0 : t2_p_ff + sra(t2_a_ff + t2_b_ff + p7, 4);
         rsp_f_ff <= t2_fine_ff;
         rsp_z_ff <= t2_z_ff;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.pressure_pa = rsp_p_ff;
   assign rsp.fine_temperature = rsp_f_ff;
   assign rsp.zero_divisor = rsp_z_ff;

   `BPC_ASSERT(a_stall_hold, clock, reset, rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.pressure_pa))
   `BPC_ASSERT(a_zero_pa, clock, reset, rsp.valid && rsp.zero_divisor |-> rsp.pressure_pa == '0)
   `BPC_ASSERT(a_ready, clock, reset, req.ready == (!rsp.valid || rsp.ready))
   `BPC_ASSERT_RST(a_reset, clock, $past(reset) |-> !rsp.valid)
endmodule

// ===== dv/bpc_tb_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces come from the RTL; this file holds the shared test types.
package bpc_tb_pkg;
   typedef struct {
      logic [31:0] pressure_pa;
      logic [31:0] fine_temperature;
      logic        zero_divisor;
   } pressure_result_type;
endpackage

// ===== dv/barometric_pressure_compensation_top_test.sv =====
`timescale 1ns / 1ps
module barometric_pressure_compensation_top_test;
   import bpc_pkg::*;
   import bpc_tb_pkg::*;

   localparam int Latency = 46;
   localparam int CycleLimit = 400000;

   logic clock;
   logic reset;
   logic csr_write;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0] csr_data;

   bpc_req_if req ();
   bpc_rsp_if rsp ();

   barometric_pressure_compensation_top dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // trim shadow
   logic [47:0] trim_temp;
   logic [63:0] trim_pa;
   logic [63:0] trim_pb;
   logic [15:0] trim_pc;

   pressure_result_type pending_pressure[$];
   int error_count = 0;
   int cycles = 0;
   bit long_hold_req = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] asr(logic [31:0] x, int s);
      return $signed(x) >>> s;
   endfunction

   function automatic logic [31:0] sext(logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic pressure_result_type compensate(logic [19:0] praw, logic [19:0] traw);
      pressure_result_type r;
      logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] a, b, d, q, sq, fine, p, tr, pr;
      tr = {12'd0, traw};
      pr = {12'd0, praw};
      t1 = {16'd0, trim_temp[15:0]};
      t2 = sext(trim_temp[31:16]);
      t3 = sext(trim_temp[47:32]);
      p1 = {16'd0, trim_pa[15:0]};
      p2 = sext(trim_pa[31:16]);
      p3 = sext(trim_pa[47:32]);
      p4 = sext(trim_pa[63:48]);
      p5 = sext(trim_pb[15:0]);
      p6 = sext(trim_pb[31:16]);
      p7 = sext(trim_pb[47:32]);
      p8 = sext(trim_pb[63:48]);
      p9 = sext(trim_pc);
      a = asr(((tr >> 3) - (t1 << 1)) * t2, 11);
      d = (tr >> 4) - t1;
      b = asr(asr(d * d, 12) * t3, 14);
      fine = a + b;
      a = asr(fine, 1) - 32'd64000;
      q = asr(a, 2);
      sq = q * q;
      b = asr(sq, 11) * p6;
      b = b + ((a * p5) << 1);
      b = asr(b, 2) + (p4 << 16);
      a = asr(asr(p3 * asr(sq, 13), 3) + asr(p2 * a, 1), 18);
      a = asr((32'd32768 + a) * p1, 15);
      r.fine_temperature = fine;
      if (a == 0) begin
         r.pressure_pa = '0;
         r.zero_divisor = 1'b1;
         return r;
      end
      p = ((32'd1048576 - pr) - asr(b, 12)) * 32'd3125;
      if (p < 32'h8000_0000)
         p = (p << 1) / a;
      else
         p = (p / a) * 32'd2;
      q = p >> 3;
      a = asr(p9 * ((q * q) >> 13), 12);
      b = asr((p >> 2) * p8, 13);
      p = p + asr(a + b + p7, 4);
      r.pressure_pa = p;
      r.zero_divisor = 1'b0;
      return r;
   endfunction

   function automatic void enqueue_expected(pressure_result_type r);
      pending_pressure = {pending_pressure, r};
   endfunction

   task automatic write_trim(logic [CsrIndexWidth-1:0] idx, logic [63:0] value);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 0;
      case (idx)
         CSR_TEMP_TRIM: trim_temp = value[47:0];
         CSR_PRES_TRIM_A: trim_pa = value;
         CSR_PRES_TRIM_B: trim_pb = value;
         CSR_PRES_TRIM_C: trim_pc = value[15:0];
         default: ;
      endcase
   endtask

   // valid stays high after a transfer; it drops only for a gap or in settle()
   task automatic send_sample(logic [19:0] praw, logic [19:0] traw, int gap);
      if (gap > 0) begin
         req.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1;
      req.raw_pressure <= praw;
      req.raw_temperature <= traw;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      enqueue_expected(compensate(praw, traw));
   endtask

   task automatic settle();
      req.valid <= 0;
      while (pending_pressure.size() != 0) @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // typical datasheet-like trims
   localparam logic [47:0] TypTemp = {16'd50, 16'd26435, 16'd27504};
   localparam logic [63:0] TypPa = {16'd2855, 16'hD0A8, 16'hD5D0, 16'd36477};
   localparam logic [63:0] TypPb = {16'hE80A, 16'd15500, 16'hFFF9, 16'd140};

   typedef struct {
      logic [19:0] praw;
      logic [19:0] traw;
      bit          fixed;
      logic [31:0] pressure_pa;
      logic [31:0] fine_temperature;
      logic        zero_divisor;
   } stim_row_type;

   // with all trims zero: fine = 0, divisor 0
   stim_row_type reset_rows[4] = '{
      '{20'h00000, 20'h00000, 1'b1, 32'd0, 32'd0, 1'b1},
      '{20'hFFFFF, 20'hFFFFF, 1'b1, 32'd0, 32'd0, 1'b1},
      '{20'h55555, 20'hAAAAA, 1'b1, 32'd0, 32'd0, 1'b1},
      '{20'hAAAAA, 20'h55555, 1'b1, 32'd0, 32'd0, 1'b1}
   };
   stim_row_type typ_rows[6] = '{
      '{20'd415148, 20'd519888, 1'b0, 32'd0, 32'd0, 1'b0},
      '{20'h00000, 20'h00000, 1'b0, 32'd0, 32'd0, 1'b0},
      '{20'hFFFFF, 20'hFFFFF, 1'b0, 32'd0, 32'd0, 1'b0},
      '{20'h00000, 20'hFFFFF, 1'b0, 32'd0, 32'd0, 1'b0},
      '{20'hFFFFF, 20'h00000, 1'b0, 32'd0, 32'd0, 1'b0},
      '{20'h80000, 20'h80000, 1'b0, 32'd0, 32'd0, 1'b0}
   };

   initial begin
      reset = 1;
      csr_write = 0;
      csr_index = '0;
      csr_data = '0;
      req.valid = 0;
      req.raw_pressure = '0;
      req.raw_temperature = '0;
      trim_temp = '0;
      trim_pa = '0;
      trim_pb = '0;
      trim_pc = '0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (reset_rows[i]) begin
         send_sample(reset_rows[i].praw, reset_rows[i].traw, pick_gap());
         if (reset_rows[i].fixed) begin
            pending_pressure[$].pressure_pa = reset_rows[i].pressure_pa;
            pending_pressure[$].fine_temperature = reset_rows[i].fine_temperature;
            pending_pressure[$].zero_divisor = reset_rows[i].zero_divisor;
         end
      end
      settle();

      write_trim(CSR_TEMP_TRIM, {16'hBEEF, TypTemp});
      write_trim(CSR_PRES_TRIM_A, TypPa);
      write_trim(CSR_PRES_TRIM_B, TypPb);
      write_trim(CSR_PRES_TRIM_C, 64'd6000);
      foreach (typ_rows[i]) send_sample(typ_rows[i].praw, typ_rows[i].traw, pick_gap());
      settle();

      // extreme trims, P1 = 0 forces a zero divisor with nonzero fine value
      write_trim(CSR_TEMP_TRIM, 64'hFFFF_7FFF_FFFF);
      write_trim(CSR_PRES_TRIM_A, 64'h8000_7FFF_8000_0000);
      write_trim(CSR_PRES_TRIM_B, 64'hFFFF_FFFF_FFFF_FFFF);
      write_trim(CSR_PRES_TRIM_C, 64'h8000);
      send_sample(20'hFFFFF, 20'h12345, 0);
      send_sample(20'h00000, 20'hFFFFF, 0);
      settle();
      write_trim(CSR_PRES_TRIM_A, 64'h7FFF_8000_7FFF_FFFF);
      write_trim(CSR_PRES_TRIM_B, 64'h8000_7FFF_8000_7FFF);
      write_trim(CSR_PRES_TRIM_C, 64'h7FFF);
      for (int i = 0; i < 6; i++)
         send_sample(20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)), 0);
      settle();

      // long receiver hold while the sender keeps offering
      write_trim(CSR_TEMP_TRIM, 64'(TypTemp));
      write_trim(CSR_PRES_TRIM_A, TypPa);
      write_trim(CSR_PRES_TRIM_B, TypPb);
      write_trim(CSR_PRES_TRIM_C, 64'd6000);
      long_hold_req = 1;
      for (int i = 0; i < 120; i++) send_sample(20'($urandom_range(0, 20'hFFFFF)),
         20'($urandom_range(0, 20'hFFFFF)), 0);
      settle();

      for (int phase = 0; phase < 8; phase++) begin
         if (phase % 2 == 0) begin
            write_trim(CSR_TEMP_TRIM, {$urandom, $urandom});
            write_trim(CSR_PRES_TRIM_A, {$urandom, $urandom});
            write_trim(CSR_PRES_TRIM_B, {$urandom, $urandom});
            write_trim(CSR_PRES_TRIM_C, {$urandom, $urandom});
         end else begin
            // near-typical trims with random jitter keep the math meaningful
            write_trim(CSR_TEMP_TRIM, 64'(TypTemp ^ {16'($urandom_range(0, 255)), 8'd0,
               8'($urandom), 16'($urandom_range(0, 4095))}));
            write_trim(CSR_PRES_TRIM_A, TypPa ^ {32'($urandom_range(0, 255)),
               32'($urandom_range(0, 65535))});
            write_trim(CSR_PRES_TRIM_B, TypPb ^ {$urandom & 32'h00FF_00FF, $urandom & 32'h00FF_00FF});
            write_trim(CSR_PRES_TRIM_C, 64'($urandom_range(0, 12000)));
         end
         for (int i = 0; i < 230; i++)
            send_sample(20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)),
               pick_gap());
         settle();
      end

      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // receiver side: random stalls plus one long hold
   initial begin
      int hold;
      rsp.ready = 0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 0;
            rsp.ready <= 0;
            hold = 0;
            while (hold < 300) begin
               @(posedge clock);
               hold++;
            end
         end
         rsp.ready <= (pick_gap() == 0);
      end
   end

   always @(posedge clock) begin
      pressure_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_pressure.size() == 0) begin
            $error("unexpected result transfer");
            error_count++;
         end else begin
            want = pending_pressure.pop_front();
            if (rsp.pressure_pa !== want.pressure_pa) begin
               $error("pressure_pa expected %0h actual %0h", want.pressure_pa, rsp.pressure_pa);
               error_count++;
            end
            if (rsp.fine_temperature !== want.fine_temperature) begin
               $error("fine_temperature expected %0h actual %0h",
                  want.fine_temperature, rsp.fine_temperature);
               error_count++;
            end
            if (rsp.zero_divisor !== want.zero_divisor) begin
               $error("zero_divisor expected %0b actual %0b", want.zero_divisor,
                  rsp.zero_divisor);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end
endmodule
